// File: src/sitda_pkg.sv
package sitda_pkg;

  localparam int NUM_POW  = 10;
  localparam int NUM_MULT = 9;

  localparam logic [5:0] ASCII_ZERO  = 6'd48;
  localparam logic [5:0] ASCII_MINUS = 6'd45;

  typedef logic [3:0]  pow_idx_t;
  typedef logic [33:0] wide_t;
  typedef logic [NUM_POW-1:0][NUM_MULT-1:0][33:0] mult_tab_t;

  typedef struct packed {
    logic     neg;
    logic     [31:0] mag;
    pow_idx_t pow;
  } job_t;

  typedef enum logic {
    ST_IDLE,
    ST_DIGITS
  } back_state_e;

  // Entry [p][k] holds (k + 1) * 10**p.
  function automatic mult_tab_t build_mult_tab();
    mult_tab_t tab;
    wide_t     pw;
    pw = 34'd1;
    for (int p = 0; p < NUM_POW; p++) begin
      for (int k = 0; k < NUM_MULT; k++) begin
        tab[p][k] = 34'(pw * 34'(k + 1));
      end
      pw = 34'(pw * 34'd10);
    end
    return tab;
  endfunction

  localparam mult_tab_t MULT_TAB = build_mult_tab();

endpackage

// File: src/sitda_if.sv
interface sitda_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface sitda_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

// File: src/sitda_front.sv
module sitda_front
  import sitda_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sitda_in_if.sink    in_i,
  output logic        push_o,
  output job_t        job_o,
  input  logic        ready_i
);

  logic        stage_valid_q;
  logic        neg_q;
  logic [31:0] mag_q;
  logic [31:0] raw;
  logic [31:0] mag_d;
  logic        accept;
  pow_idx_t    pow;

  assign in_i.ready = !stage_valid_q || ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign raw        = in_i.value;
  assign mag_d      = raw[31] ? 32'(~raw + 32'd1) : raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      stage_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      neg_q <= raw[31];
      mag_q <= mag_d;
    end
  end

  // The digit count follows from the highest power of ten not above the magnitude.
  always_comb begin
    pow = '0;
    for (int p = 1; p < NUM_POW; p++) begin
      if ({2'b00, mag_q} >= MULT_TAB[p][0]) begin
        pow = pow_idx_t'(p);
      end
    end
  end

  assign push_o    = stage_valid_q;
  assign job_o.neg = neg_q;
  assign job_o.mag = mag_q;
  assign job_o.pow = pow;

endmodule

// File: src/sitda_queue.sv
module sitda_queue
  import sitda_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic ready_o,
  output logic head_valid_o,
  output job_t head_o,
  input  logic pop_i
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             wr;
  logic             rd;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(ptr + 1'b1);
  endfunction

  assign ready_o      = count_q != CNT_W'(DEPTH);
  assign head_valid_o = count_q != '0;
  assign head_o       = mem_q[rd_ptr_q];
  assign wr           = push_i && ready_o;
  assign rd           = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (rd) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (wr && !rd) begin
        count_q <= CNT_W'(count_q + 1'b1);
      end else if (rd && !wr) begin
        count_q <= CNT_W'(count_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue fill count exceeds its depth");

endmodule

// File: src/sitda_back.sv
module sitda_back
  import sitda_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  job_t        head_i,
  output logic        pop_o,
  sitda_out_if.source out_o
);

  back_state_e st_q, st_d;
  logic        out_valid_q, out_valid_d;
  logic [5:0]  char_q, char_d;
  logic        last_q, last_d;
  logic [31:0] rem_q, rem_d;
  pow_idx_t    pow_q, pow_d;
  logic        adv;

  logic [31:0]         src;
  pow_idx_t            p;
  logic [NUM_MULT-1:0] ge;
  logic [3:0]          digit;
  wide_t               sub;
  logic [31:0]         rem_next;
  pow_idx_t            pow_next;
  logic [5:0]          digit_char;

  assign adv = !out_valid_q || out_o.ready;

  // One decimal digit per cycle while out_o is not stalled: compare against all nine multiples of the current power.
  always_comb begin
    src = (st_q == ST_DIGITS) ? rem_q : head_i.mag;
    p   = (st_q == ST_DIGITS) ? pow_q : head_i.pow;
    for (int k = 0; k < NUM_MULT; k++) begin
      ge[k] = {2'b00, src} >= MULT_TAB[p][k];
    end
    digit = '0;
    sub   = '0;
    for (int k = 0; k < NUM_MULT; k++) begin
      if (ge[k]) begin
        digit = 4'(k + 1);
        sub   = MULT_TAB[p][k];
      end
    end
    rem_next   = src - sub[31:0];
    pow_next   = (p == '0) ? '0 : pow_idx_t'(p - 1'b1);
    digit_char = ASCII_ZERO + {2'b00, digit};
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (adv && head_valid_i && (head_i.neg || head_i.pow != '0)) begin
          st_d = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (adv && pow_q == '0) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    char_d      = char_q;
    last_d      = last_q;
    rem_d       = rem_q;
    pow_d       = pow_q;
    case (st_q)
      ST_IDLE: begin
        if (adv && head_valid_i) begin
          pop_o       = 1'b1;
          out_valid_d = 1'b1;
          if (head_i.neg) begin
            char_d = ASCII_MINUS;
            last_d = 1'b0;
            rem_d  = head_i.mag;
            pow_d  = head_i.pow;
          end else begin
            char_d = digit_char;
            last_d = head_i.pow == '0;
            rem_d  = rem_next;
            pow_d  = pow_next;
          end
        end
      end
      ST_DIGITS: begin
        if (adv) begin
          out_valid_d = 1'b1;
          char_d      = digit_char;
          last_d      = pow_q == '0;
          rem_d       = rem_next;
          pow_d       = pow_next;
        end
      end
      default: begin
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    rem_q  <= rem_d;
    pow_q  <= pow_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.character = char_q;
  assign out_o.last      = last_q;

  a_rem_below_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIGITS && pow_q < pow_idx_t'(NUM_POW - 1)) |->
      ({2'b00, rem_q} < MULT_TAB[pow_idx_t'(pow_q + 1'b1)][0]))
    else $error("remainder does not fit the remaining digit count");

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (char_q == ASCII_MINUS) ||
      (char_q >= ASCII_ZERO && char_q <= ASCII_ZERO + 6'd9))
    else $error("character is neither a digit nor a minus sign");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && char_q == ASCII_MINUS) |-> !last_q)
    else $error("minus sign marked as the final character");

endmodule

// File: src/signed_int_to_decimal_ascii_top.sv
// Channel  Direction  Payload                  Handshake
// in_i     sink       value[31:0] signed       valid/ready
// out_o    source     character[5:0], last     valid/ready
//
// Each number leaves as one to eleven characters, one per cycle while out_o is not stalled,
// produced digit by digit by the single-digit unit in the back end.
// A number passes the front-end stage register and the queue before the back end registers its first character.
// Reset clears the handshake and sequencing state only; there is no clearing pass.
// A stall on out_o freezes the back end, while the front end and the queue keep
// taking up to QUEUE_DEPTH + 1 further numbers.
module signed_int_to_decimal_ascii_top
  import sitda_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sitda_in_if.sink    in_i,
  sitda_out_if.source out_o
);

  logic push;
  job_t job;
  logic queue_ready;
  logic head_valid;
  job_t head;
  logic pop;

  sitda_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .push_o  (push),
    .job_o   (job),
    .ready_i (queue_ready)
  );

  sitda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (job),
    .ready_o      (queue_ready),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  sitda_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule
